### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile away when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CMAS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define CMAS_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define CMAS_ASSERT(label, clk, rst, prop)
`define CMAS_NEVER(label, clk, rst, expr)
`endif
`endif

### rtl/core/cmas_pkg.sv
// ----------------------------------------------------------------------------
// cmas_pkg
// Shared widths, codes and types of the moving average smoother.
// ----------------------------------------------------------------------------
package cmas_pkg;

   localparam int SAMPLE_W   = 32;
   localparam int SPAN_W     = 6;
   localparam int CNT_W      = 6;
   localparam int HALF_W     = 5;
   localparam int SUM_W      = 38;
   localparam int HIST_AW    = 6;
   localparam int HALF_LIMIT = 31;
   localparam int Q_DEPTH    = 4;
   localparam int Q_AW       = 2;
   localparam int STEP_W     = 6;
   localparam int ADDR_W     = 3;

   // Register index of the span register.
   localparam logic REG_SPAN = 1'b0;

   // One division job: window sum, samples in the window, end-of-block mark.
   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic [CNT_W-1:0]        count;
      logic                    last_out;
   } job_type;

endpackage

### rtl/core/cmas_fifo.sv
// ----------------------------------------------------------------------------
// cmas_fifo
// Small job queue between the window front end and the divider.
// ----------------------------------------------------------------------------
module cmas_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmas_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output cmas_pkg::job_type pop_data,
   output logic             empty
);
   import cmas_pkg::*;

   job_type          store_ff [Q_DEPTH];
   logic [Q_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [Q_AW:0]    fill_ff, fill_in;

   assign full     = (fill_ff == (Q_AW+1)'(Q_DEPTH));
   assign empty    = (fill_ff == '0);
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + Q_AW'(push);
      rd_ptr_in = rd_ptr_ff + Q_AW'(pop);
      fill_in   = fill_ff + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/cmas_front.sv
// ----------------------------------------------------------------------------
// cmas_front
// Takes samples, keeps the history and a running window sum, and queues one
// division job for every smoothed value the sample releases.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module cmas_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [cmas_pkg::SPAN_W-1:0]     window_span,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [cmas_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                            req_block_end,
   output logic                            push,
   output cmas_pkg::job_type               push_data,
   input  logic                            q_full
);
   import cmas_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_TRIM = 2'd1;
   localparam logic [1:0] ST_DROP = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic signed [SAMPLE_W-1:0] hist_mem [2**HIST_AW];
   logic signed [SAMPLE_W-1:0] rdata_ff;
   logic [HIST_AW-1:0]      wptr_ff, wptr_in, rd_addr;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   // One bit wider than the count: a full window plus the new sample is 64.
   logic [CNT_W:0]          wcnt_ff, wcnt_in;
   logic [CNT_W-1:0]        rc_ff, rc_in, rc_next;
   logic [HALF_W-1:0]       h_ff, h_in, h_sel, span_h;
   logic [HALF_W-1:0]       m_ff, m_in;
   logic                    last_ff, last_in;
   logic [CNT_W:0]          lim, target;
   logic                    accept;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rd_addr   = wptr_ff - HIST_AW'(wcnt_ff);

   always_comb begin
      span_h = (window_span >> 1) > SPAN_W'(HALF_LIMIT) ? HALF_W'(HALF_LIMIT)
                                                       : HALF_W'(window_span >> 1);
      h_sel  = (rc_ff == '0) ? span_h : h_ff;
      rc_next = (rc_ff == '1) ? rc_ff : rc_ff + 1'b1;
      // Window size wanted now: full span, or the shrinking flush window.
      lim = last_ff ? ((CNT_W+1)'(m_ff) + (CNT_W+1)'(h_ff) + 1'b1)
                    : ((CNT_W+1)'({h_ff, 1'b0}) + 1'b1);
      target = (lim > (CNT_W+1)'(rc_ff)) ? (CNT_W+1)'(rc_ff) : lim;
   end

   always_comb begin
      state_in  = state_ff;
      wptr_in   = wptr_ff;
      sum_in    = sum_ff;
      wcnt_in   = wcnt_ff;
      rc_in     = rc_ff;
      h_in      = h_ff;
      m_in      = m_ff;
      last_in   = last_ff;
      push      = 1'b0;
      push_data = '{sum: sum_ff, count: CNT_W'(wcnt_ff), last_out: 1'b0};
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               wptr_in = wptr_ff + 1'b1;
               h_in    = h_sel;
               rc_in   = rc_next;
               last_in = req_block_end;
               if (rc_ff == '0) begin
                  sum_in  = SUM_W'(req_sample);
                  wcnt_in = (CNT_W+1)'(1);
               end else begin
                  sum_in  = sum_ff + SUM_W'(req_sample);
                  wcnt_in = wcnt_ff + 1'b1;
               end
               m_in = ((rc_next - 1'b1) > CNT_W'(h_sel)) ? h_sel
                                                          : HALF_W'(rc_next - 1'b1);
               state_in = ST_TRIM;
            end
         end
         ST_TRIM: begin
            if (wcnt_ff > target) begin
               state_in = ST_DROP;
            end else if (!last_ff) begin
               if (rc_ff > CNT_W'(h_ff)) begin
                  if (!q_full) begin
                     push     = 1'b1;
                     state_in = ST_IDLE;
                  end
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (!q_full) begin
               push      = 1'b1;
               push_data = '{sum: sum_ff, count: CNT_W'(wcnt_ff), last_out: (m_ff == '0)};
               if (m_ff == '0) begin
                  rc_in    = '0;
                  state_in = ST_IDLE;
               end else begin
                  m_in = m_ff - 1'b1;
               end
            end
         end
         ST_DROP: begin
            sum_in   = sum_ff - SUM_W'(rdata_ff);
            wcnt_in  = wcnt_ff - 1'b1;
            state_in = ST_TRIM;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wptr_ff  <= '0;
         rc_ff    <= '0;
         wcnt_ff  <= '0;
         h_ff     <= '0;
         m_ff     <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         wptr_ff  <= wptr_in;
         rc_ff    <= rc_in;
         wcnt_ff  <= wcnt_in;
         h_ff     <= h_in;
         m_ff     <= m_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hist_mem[wptr_ff] <= req_sample;
      end
      rdata_ff <= hist_mem[rd_addr];
   end

   `CMAS_ASSERT(a_wcnt_le_rc, clock, reset, (state_ff == ST_TRIM) |-> (wcnt_ff <= (CNT_W+1)'(rc_ff) + 1'b1))
   `CMAS_NEVER(a_push_full, clock, reset, push && q_full)
   `CMAS_ASSERT(a_drop_from_trim, clock, reset, (state_ff == ST_DROP) |-> ($past(state_ff) == ST_TRIM))

endmodule

### rtl/core/cmas_back.sv
// ----------------------------------------------------------------------------
// cmas_back
// Serial divider: one quotient bit per cycle, then the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module cmas_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_empty,
   input  cmas_pkg::job_type               pop_data,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [cmas_pkg::SAMPLE_W-1:0] rsp_smoothed,
   output logic                            rsp_final_result
);
   import cmas_pkg::*;

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_DIV  = 2'd1;
   localparam logic [1:0] B_DONE = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [SUM_W-1:0]    quo_ff, quo_in, quo_fix;
   logic [CNT_W-1:0]    rem_ff, rem_in, div_ff;
   logic [CNT_W:0]      rem_sh;
   logic                ge;
   logic                neg_ff, fin_ff;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                out_valid_ff, out_valid_in, load_out;
   logic [SAMPLE_W-1:0] out_data_ff;
   logic                out_fin_ff;

   assign rsp_valid        = out_valid_ff;
   assign rsp_smoothed     = out_data_ff;
   assign rsp_final_result = out_fin_ff;
   assign pop              = (state_ff == B_IDLE) && !q_empty;
   assign load_out         = (state_ff == B_DONE) && (!out_valid_ff || rsp_ready);

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[SUM_W-1]};
      ge      = rem_sh >= (CNT_W+1)'(div_ff);
      rem_in  = ge ? CNT_W'(rem_sh - (CNT_W+1)'(div_ff)) : CNT_W'(rem_sh);
      quo_in  = {quo_ff[SUM_W-2:0], ge};
      quo_fix = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
      step_in = step_ff;
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            step_in = '0;
            if (!q_empty) state_in = B_DIV;
         end
         B_DIV: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(SUM_W - 1)) state_in = B_DONE;
         end
         B_DONE: begin
            if (load_out) state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
      out_valid_in = load_out || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         neg_ff <= pop_data.sum[SUM_W-1];
         quo_ff <= pop_data.sum[SUM_W-1] ? SUM_W'(-pop_data.sum) : SUM_W'(pop_data.sum);
         div_ff <= pop_data.count;
         fin_ff <= pop_data.last_out;
         rem_ff <= '0;
      end else if (state_ff == B_DIV) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
      if (load_out) begin
         out_data_ff <= quo_fix[SAMPLE_W-1:0];
         out_fin_ff  <= fin_ff;
      end
   end

   `CMAS_ASSERT(a_step_bound, clock, reset, (state_ff == B_DIV) |-> (step_ff < STEP_W'(SUM_W)))
   `CMAS_ASSERT(a_rem_lt_div, clock, reset, (state_ff == B_DIV) |-> (rem_ff < div_ff))
   `CMAS_ASSERT(a_load_free, clock, reset, load_out |-> (!out_valid_ff || rsp_ready))

endmodule

### rtl/core/centered_moving_average_smoother_core.sv
// ----------------------------------------------------------------------------
// centered_moving_average_smoother_core
// A value's path: the front end accepts its request, trims the window with one
// drop step per sample leaving it and queues a job; the divider pops the job,
// runs 38 divider steps and unloads it; it takes one job at a time, in order.
// The front end takes no new request until it has queued the last one's jobs.
// Reset (synchronous, active high) clears the block state and sets span to 5.
// The history memory needs no clearing pass; it is read only after writing.
// ----------------------------------------------------------------------------
module centered_moving_average_smoother_core (
   input  logic                            clock,
   input  logic                            reset,
   // Sample requests.
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [cmas_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                            req_block_end,
   // Smoothed results.
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [cmas_pkg::SAMPLE_W-1:0] rsp_smoothed,
   output logic                            rsp_final_result,
   // Register port.
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [cmas_pkg::ADDR_W-1:0]     paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import cmas_pkg::*;

   // The span register is sampled by the front end at the first request of
   // each block, so a write during a block takes effect with the next block.
   logic [SPAN_W-1:0] span_ff, span_in;
   logic              reg_wr;
   logic              q_push, q_pop, q_full, q_empty;
   job_type           q_in, q_out;

   assign pready = 1'b1;
   assign reg_wr = psel && penable && pwrite && (paddr[2] == REG_SPAN);
   assign span_in = reg_wr ? pwdata[SPAN_W-1:0] : span_ff;
   assign prdata = (paddr[2] == REG_SPAN) ? 32'(span_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff <= SPAN_W'(5);
      end else begin
         span_ff <= span_in;
      end
   end

   // The front end keeps a running window sum and queues one job per result.
   cmas_front u_front (
      .clock         (clock),
      .reset         (reset),
      .window_span   (span_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample    (req_sample),
      .req_block_end (req_block_end),
      .push          (q_push),
      .push_data     (q_in),
      .q_full        (q_full)
   );

   // A short queue lets the front end run ahead of the divider.
   cmas_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   // The back end divides each sum by its sample count, toward zero.
   cmas_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .pop_data         (q_out),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_smoothed     (rsp_smoothed),
      .rsp_final_result (rsp_final_result)
   );

endmodule
